// ===== hw/rtl/tcon_pkg.sv =====
// ----------------------------------------------------------------------------
// tcon_pkg
// Shared types and constants for the text console with key FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package tcon_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IROW_W  = 5;
  localparam int unsigned ICOL_W  = 6;

  localparam logic [BYTE_W-1:0] GLYPH_CURSOR = 8'd228;
  localparam logic [BYTE_W-1:0] CODE_BS      = 8'd8;
  localparam logic [BYTE_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [BYTE_W-1:0] CODE_NL      = 8'd10;
  localparam logic [BYTE_W-1:0] CODE_SPACE   = 8'd32;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 3'd0,
    OP_CLEAR = 3'd1,
    OP_PUSH  = 3'd2,
    OP_POP   = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CH_OTHER,
    CH_NL,
    CH_BS,
    CH_TAB
  } chr_e;

  // What a place step stores: the working char, a space, or the cursor glyph
  typedef enum logic [1:0] {
    PUT_WCHAR,
    PUT_ZERO,
    PUT_SPACE
  } put_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_INIT_SWEEP,
    CMD_CLR_START,
    CMD_CLR_SWEEP,
    CMD_PUSH,
    CMD_POP_TAKE,
    CMD_CELL_TAKE,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_WRAP,
    CMD_SCROLL,
    CMD_SWEEP_ROW,
    CMD_PUT,
    CMD_RESULT
  } cmd_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_CELL_TK,
    S_WCHAR,
    S_WRAP,
    S_CHECK,
    S_ROW_CLR,
    S_PUT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] char_code;
    logic              no_echo;
    logic [IROW_W-1:0] cell_row;
    logic [ICOL_W-1:0] cell_col;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              key_valid;
    logic              key_dropped;
    logic [ICOL_W-1:0] cursor_col_out;
    logic [IROW_W-1:0] cursor_row_out;
  } out_t;

  typedef struct packed {
    cmd_e cmd;
    put_e put_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic no_echo;
    chr_e chr;
    logic scroll_needed;
    logic sweep_all_last;
    logic sweep_row_last;
    logic fifo_empty;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/text_console_with_key_fifo.sv =====
// ----------------------------------------------------------------------------
// text_console_with_key_fifo
// Character console over a ring of rows, with scroll and a key FIFO.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  in      | input     | in_valid_i/in_stall_o | in_i  (tcon_pkg::in_t)
//  out     | output    | out_valid_o/out_stall_i | out_o (tcon_pkg::out_t)
//
//  One item is worked at a time; the sequencer steps the datapath.
//  A scroll adds row clearing through the single cell store write port;
//  clear screen sweeps the whole store. After reset the store is swept,
//  with in_stall_o high, to zero it and place the cursor glyph in the
//  first cell.
//  A finished item waits in the output register while the next one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_with_key_fifo #(
  parameter int unsigned COLUMNS        = 40,
  parameter int unsigned ROWS           = 22,
  parameter int unsigned KEY_FIFO_DEPTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  tcon_pkg::in_t       in_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output tcon_pkg::out_t      out_o
);
  import tcon_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: decode, walk sweeps, hold the result until the sink frees up
  tcon_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: cell store, cursor and ring offset, key FIFO, result register
  tcon_dpath #(
    .COLUMNS        (COLUMNS),
    .ROWS           (ROWS),
    .KEY_FIFO_DEPTH (KEY_FIFO_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tcon_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcon_ctrl
// Sequencer for the console: decodes each item and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tcon_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  tcon_pkg::dp_status_t     status_i,
  output tcon_pkg::ctrl_cmd_t      cmd_o
);
  import tcon_pkg::*;

  state_e state_q, state_d;
  put_e   kind_q, kind_d;
  logic   second_q, second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      kind_q   <= PUT_WCHAR;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    second_d      = second_q;
    cmd_o.cmd     = CMD_NONE;
    cmd_o.put_sel = kind_q;
    in_stall_o    = (state_q != S_IDLE);
    case (state_q)
      S_INIT: begin
        cmd_o.cmd = CMD_INIT_SWEEP;
        if (status_i.sweep_all_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cmd = CMD_LATCH;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status_i.op)
          OP_WRITE: state_d = S_WCHAR;
          OP_CLEAR: begin
            cmd_o.cmd = CMD_CLR_START;
            state_d   = S_CLEAR;
          end
          OP_PUSH: begin
            cmd_o.cmd = CMD_PUSH;
            state_d   = S_DONE;
          end
          OP_POP: begin
            if (status_i.fifo_empty) begin
              state_d = S_DONE;
            end else begin
              cmd_o.cmd = CMD_POP_TAKE;
              state_d   = status_i.no_echo ? S_DONE : S_WCHAR;
            end
          end
          OP_READ: state_d = S_CELL_TK;
          default: state_d = S_DONE;
        endcase
      end
      S_CLEAR: begin
        cmd_o.cmd = CMD_CLR_SWEEP;
        if (status_i.sweep_all_last) state_d = S_DONE;
      end
      S_CELL_TK: begin
        cmd_o.cmd = CMD_CELL_TAKE;
        state_d   = S_DONE;
      end
      S_WCHAR: begin
        case (status_i.chr)
          CH_NL: begin
            cmd_o.cmd = CMD_NEWLINE;
            kind_d    = PUT_ZERO;
            state_d   = S_CHECK;
          end
          CH_BS: begin
            cmd_o.cmd = CMD_BACKSPACE;
            state_d   = S_DONE;
          end
          CH_TAB: begin
            cmd_o.cmd = CMD_WRAP;
            kind_d    = PUT_SPACE;
            second_d  = 1'b0;
            state_d   = S_CHECK;
          end
          default: begin
            cmd_o.cmd = CMD_WRAP;
            kind_d    = PUT_WCHAR;
            state_d   = S_CHECK;
          end
        endcase
      end
      S_WRAP: begin
        cmd_o.cmd = CMD_WRAP;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.scroll_needed) begin
          cmd_o.cmd = CMD_SCROLL;
          state_d   = S_ROW_CLR;
        end else begin
          cmd_o.cmd = CMD_PUT;
          if (kind_q == PUT_SPACE && !second_q) begin
            second_d = 1'b1;
            state_d  = S_WRAP;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_ROW_CLR: begin
        cmd_o.cmd = CMD_SWEEP_ROW;
        if (status_i.sweep_row_last) state_d = S_PUT;
      end
      S_PUT: begin
        cmd_o.cmd = CMD_PUT;
        if (kind_q == PUT_SPACE && !second_q) begin
          second_d = 1'b1;
          state_d  = S_WRAP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.cmd = CMD_RESULT;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // A new item is taken only from idle
  a_latch_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.cmd == CMD_LATCH) |=> (state_q == S_DECODE))
    else $error("latch did not lead to decode");
  a_result_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.cmd == CMD_RESULT) |=> (state_q == S_IDLE))
    else $error("result did not return to idle");
  a_tab_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRAP) |-> (second_q && kind_q == PUT_SPACE))
    else $error("second wrap outside a tab");

endmodule

`default_nettype wire

// ===== hw/rtl/tcon_dpath.sv =====
// ----------------------------------------------------------------------------
// tcon_dpath
// Cell store, cursor, scroll ring, key FIFO and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcon_dpath #(
  parameter int unsigned COLUMNS        = 40,
  parameter int unsigned ROWS           = 22,
  parameter int unsigned KEY_FIFO_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  tcon_pkg::in_t            in_i,
  input  tcon_pkg::ctrl_cmd_t      cmd_i,
  output tcon_pkg::dp_status_t     status_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tcon_pkg::out_t           out_o
);
  import tcon_pkg::*;

  localparam int unsigned N     = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(N);
  localparam int unsigned TOP_W = $clog2(ROWS);
  localparam int unsigned RW    = $clog2(ROWS + 1);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned FA_W  = $clog2(KEY_FIFO_DEPTH);
  localparam int unsigned FC_W  = $clog2(KEY_FIFO_DEPTH + 1);

  function automatic logic [AW-1:0] cell_addr(input logic [TOP_W-1:0] top,
                                              input logic [TOP_W-1:0] vis,
                                              input logic [CW-1:0]    col);
    logic [TOP_W:0]   s;
    logic [TOP_W-1:0] p;
    s = {1'b0, top} + {1'b0, vis};
    p = (32'(s) >= ROWS) ? TOP_W'(32'(s) - ROWS) : TOP_W'(s);
    return AW'(AW'(p) * AW'(COLUMNS) + AW'(col));
  endfunction

  // Storage
  logic [BYTE_W-1:0] cells [N];
  logic [BYTE_W-1:0] keys  [KEY_FIFO_DEPTH];

  // Control state
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic [TOP_W-1:0] top_q, top_d;
  logic [FA_W-1:0]  head_q, head_d;
  logic [FC_W-1:0]  count_q, count_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // Payload
  logic [OP_W-1:0]   op_q, op_d;
  logic              no_echo_q, no_echo_d;
  logic [IROW_W-1:0] rr_q, rr_d;
  logic [ICOL_W-1:0] cc_q, cc_d;
  logic [BYTE_W-1:0] wchar_q, wchar_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic              kv_q, kv_d, kd_q, kd_d;
  logic [AW-1:0]     base_q, base_d;
  out_t              out_q, out_d;
  logic [BYTE_W-1:0] cell_rd_q, key_rd_q;

  // Memory ports
  logic              cell_we;
  logic [AW-1:0]     cell_wa, cell_ra;
  logic [BYTE_W-1:0] cell_wd;
  logic              key_we;
  logic [FA_W-1:0]   key_wa;

  // Helpers
  logic              rd_in_range, cur_in_range, at_home;
  logic [CW-1:0]     bs_col;
  logic [RW-1:0]     bs_row;
  logic [BYTE_W-1:0] put_val;
  logic [FC_W:0]     tail_sum;
  logic              out_take;

  assign rd_in_range  = (32'(rr_q) < ROWS) && (32'(cc_q) < COLUMNS);
  assign cur_in_range = (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS);
  assign at_home      = (col_q == '0) && (row_q == '0);
  assign bs_col       = (col_q == '0) ? CW'(COLUMNS - 1) : col_q - 1'b1;
  assign bs_row       = (col_q == '0) ? row_q - 1'b1 : row_q;
  assign tail_sum     = (FC_W + 1)'(head_q) + (FC_W + 1)'(count_q);
  assign cell_ra      = rd_in_range ? cell_addr(top_q, TOP_W'(rr_q), CW'(cc_q)) : '0;
  assign out_take     = out_valid_q && !out_stall_i;

  always_comb begin
    case (cmd_i.put_sel)
      PUT_SPACE: put_val = CODE_SPACE;
      PUT_ZERO:  put_val = '0;
      default:   put_val = wchar_q;
    endcase
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    top_d       = top_q;
    head_d      = head_q;
    count_d     = count_q;
    cnt_d       = cnt_q;
    out_valid_d = out_take ? 1'b0 : out_valid_q;
    op_d        = op_q;
    no_echo_d   = no_echo_q;
    rr_d        = rr_q;
    cc_d        = cc_q;
    wchar_d     = wchar_q;
    data_d      = data_q;
    kv_d        = kv_q;
    kd_d        = kd_q;
    base_d      = base_q;
    out_d       = out_q;
    cell_we     = 1'b0;
    cell_wa     = cell_addr(top_q, TOP_W'(row_q), col_q);
    cell_wd     = '0;
    key_we      = 1'b0;
    key_wa      = (32'(tail_sum) >= KEY_FIFO_DEPTH) ?
                  FA_W'(32'(tail_sum) - KEY_FIFO_DEPTH) : FA_W'(tail_sum);
    case (cmd_i.cmd)
      CMD_LATCH: begin
        op_d      = in_i.op;
        no_echo_d = in_i.no_echo;
        rr_d      = in_i.cell_row;
        cc_d      = in_i.cell_col;
        wchar_d   = in_i.char_code;
        data_d    = '0;
        kv_d      = 1'b0;
        kd_d      = 1'b0;
      end
      CMD_INIT_SWEEP, CMD_CLR_SWEEP: begin
        cell_we = 1'b1;
        cell_wa = cnt_q;
        cell_wd = (cmd_i.cmd == CMD_INIT_SWEEP && cnt_q == '0) ? GLYPH_CURSOR : '0;
        cnt_d   = (cnt_q == AW'(N - 1)) ? '0 : cnt_q + 1'b1;
      end
      CMD_CLR_START: begin
        col_d = '0;
        row_d = '0;
        top_d = '0;
        cnt_d = '0;
      end
      CMD_PUSH: begin
        if (32'(count_q) >= KEY_FIFO_DEPTH) begin
          kd_d = 1'b1;
        end else begin
          key_we  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP_TAKE: begin
        data_d  = key_rd_q;
        kv_d    = 1'b1;
        wchar_d = key_rd_q;
        head_d  = (32'(head_q) == KEY_FIFO_DEPTH - 1) ? '0 : head_q + 1'b1;
        count_d = count_q - 1'b1;
      end
      CMD_CELL_TAKE: begin
        data_d = rd_in_range ? cell_rd_q : '0;
      end
      CMD_NEWLINE: begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end
      CMD_BACKSPACE: begin
        if (!at_home) begin
          col_d   = bs_col;
          row_d   = bs_row;
          cell_we = 1'b1;
          cell_wa = cell_addr(top_q, TOP_W'(bs_row), bs_col);
          cell_wd = CODE_SPACE;
        end
      end
      CMD_WRAP: begin
        if (32'(col_q) >= COLUMNS) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end
      end
      CMD_SCROLL: begin
        // The row that drops off the top becomes the new, blank bottom row
        row_d  = RW'(ROWS - 1);
        top_d  = (32'(top_q) == ROWS - 1) ? '0 : top_q + 1'b1;
        base_d = AW'(AW'(top_q) * AW'(COLUMNS));
        cnt_d  = '0;
      end
      CMD_SWEEP_ROW: begin
        cell_we = 1'b1;
        cell_wa = base_q + cnt_q;
        cell_wd = '0;
        cnt_d   = (cnt_q == AW'(COLUMNS - 1)) ? '0 : cnt_q + 1'b1;
      end
      CMD_PUT: begin
        cell_we = cur_in_range;
        if (put_val == '0) begin
          cell_wd = GLYPH_CURSOR;
        end else begin
          cell_wd = put_val;
          col_d   = col_q + 1'b1;
        end
      end
      CMD_RESULT: begin
        out_valid_d          = 1'b1;
        out_d.data_byte      = data_q;
        out_d.key_valid      = kv_q;
        out_d.key_dropped    = kd_q;
        out_d.cursor_col_out = ICOL_W'(col_q);
        out_d.cursor_row_out = IROW_W'(row_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      top_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      top_q       <= top_d;
      head_q      <= head_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    no_echo_q <= no_echo_d;
    rr_q      <= rr_d;
    cc_q      <= cc_d;
    wchar_q   <= wchar_d;
    data_q    <= data_d;
    kv_q      <= kv_d;
    kd_q      <= kd_d;
    base_q    <= base_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) cells[cell_wa] <= cell_wd;
    cell_rd_q <= cells[cell_ra];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) keys[key_wa] <= wchar_q;
    key_rd_q <= keys[head_q];
  end

  always_comb begin
    status_o.op             = op_e'(op_q);
    status_o.no_echo        = no_echo_q;
    status_o.scroll_needed  = (32'(row_q) >= ROWS);
    status_o.sweep_all_last = (cnt_q == AW'(N - 1));
    status_o.sweep_row_last = (cnt_q == AW'(COLUMNS - 1));
    status_o.fifo_empty     = (count_q == '0);
    status_o.out_free       = !out_valid_q || !out_stall_i;
    if (wchar_q == CODE_NL)       status_o.chr = CH_NL;
    else if (wchar_q == CODE_BS)  status_o.chr = CH_BS;
    else if (wchar_q == CODE_TAB) status_o.chr = CH_TAB;
    else                          status_o.chr = CH_OTHER;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) <= COLUMNS)
    else $error("cursor column beyond wrap position");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= KEY_FIFO_DEPTH)
    else $error("key FIFO count overflow");
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cmd == CMD_RESULT) |=> (out_valid_q && !(out_q.key_valid && out_q.key_dropped)))
    else $error("result register not loaded cleanly");

endmodule

`default_nettype wire

// ===== tb/text_console_with_key_fifo_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_with_key_fifo_tb
// Self-checking bench for the text console with key FIFO: a console and FIFO
// predictor in a small scoreboard, random and directed items, random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_with_key_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcon_pkg::*;

  localparam int COLS      = 40;
  localparam int ROWS_N    = 22;
  localparam int FIFO_D    = 16;
  localparam int N_RANDOM  = 1930;
  localparam int STALL_MAX = 4000;

  // Console and key FIFO predictor with a queue of pending results
  class console_scoreboard;
    logic [7:0] cells[ROWS_N*COLS];
    int         cur_col, cur_row, top_off;
    logic [7:0] keys[FIFO_D];
    int         key_head, key_count;
    out_t       pending[$];
    int         errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cells[0] = GLYPH_CURSOR;
      cur_col = 0; cur_row = 0; top_off = 0;
      key_head = 0; key_count = 0; errors = 0;
    endfunction

    function void put_cell(int vr, int c, logic [7:0] v);
      if (vr < ROWS_N && c < COLS) cells[((top_off + vr) % ROWS_N)*COLS + c] = v;
    endfunction

    function void place(logic [7:0] ch);
      int base;
      if (cur_col >= COLS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROWS_N) begin
        cur_row = ROWS_N - 1;
        top_off = (top_off + 1) % ROWS_N;
        base = ((top_off + ROWS_N - 1) % ROWS_N) * COLS;
        for (int i = 0; i < COLS; i++) cells[base + i] = '0;
      end
      if (ch != 0) begin
        put_cell(cur_row, cur_col, ch);
        cur_col++;
      end else begin
        put_cell(cur_row, cur_col, GLYPH_CURSOR);
      end
    endfunction

    function void write_char(logic [7:0] ch);
      if (ch == CODE_NL) begin
        cur_col = 0;
        cur_row++;
        place(8'd0);
      end else if (ch == CODE_BS) begin
        if (cur_col == 0 && cur_row == 0) return;
        if (cur_col == 0) begin
          cur_col = COLS - 1;
          cur_row--;
        end else begin
          cur_col--;
        end
        put_cell(cur_row, cur_col, CODE_SPACE);
      end else if (ch == CODE_TAB) begin
        place(CODE_SPACE);
        place(CODE_SPACE);
      end else begin
        place(ch);
      end
    endfunction

    // Note an accepted item: advance the state, queue its result
    function void note_item(in_t it);
      out_t r;
      logic [7:0] k;
      r = '0;
      case (it.op)
        OP_WRITE: write_char(it.char_code);
        OP_CLEAR: begin
          foreach (cells[i]) cells[i] = '0;
          cur_col = 0; cur_row = 0; top_off = 0;
        end
        OP_PUSH: begin
          if (key_count >= FIFO_D) r.key_dropped = 1'b1;
          else begin
            keys[(key_head + key_count) % FIFO_D] = it.char_code;
            key_count++;
          end
        end
        OP_POP: begin
          if (key_count > 0) begin
            k = keys[key_head];
            if (!it.no_echo) write_char(k);
            key_head = (key_head + 1) % FIFO_D;
            key_count--;
            r.data_byte = k;
            r.key_valid = 1'b1;
          end
        end
        OP_READ: begin
          if (it.cell_row < ROWS_N && it.cell_col < COLS)
            r.data_byte = cells[((top_off + it.cell_row) % ROWS_N)*COLS + it.cell_col];
        end
        default: ;
      endcase
      r.cursor_col_out = cur_col[5:0];
      r.cursor_row_out = cur_row[4:0];
      pending = {pending, r};
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.data_byte != e.data_byte) begin
        $error("data_byte exp %0d got %0d", e.data_byte, got.data_byte); errors++;
      end
      if (got.key_valid != e.key_valid) begin
        $error("key_valid exp %0d got %0d", e.key_valid, got.key_valid); errors++;
      end
      if (got.key_dropped != e.key_dropped) begin
        $error("key_dropped exp %0d got %0d", e.key_dropped, got.key_dropped); errors++;
      end
      if (got.cursor_col_out != e.cursor_col_out) begin
        $error("cursor_col_out exp %0d got %0d", e.cursor_col_out, got.cursor_col_out);
        errors++;
      end
      if (got.cursor_row_out != e.cursor_row_out) begin
        $error("cursor_row_out exp %0d got %0d", e.cursor_row_out, got.cursor_row_out);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_t  in_i;
  out_t out_o;

  console_scoreboard sb;
  int  idle_cycles;
  bit  calm;       // no idling on either side while set
  int  n_results;

  text_console_with_key_fifo dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .out_valid_o, .out_stall_i, .out_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: stall at random, check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_o);
      n_results++;
    end
    out_stall_i <= !calm && ($urandom_range(99) < 8);
  end

  // Watchdog: count cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX + ROWS_N*COLS*2) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one item, hold it until accepted, maybe idle afterwards
  task automatic send_item(in_t it);
    in_valid_i <= 1'b1;
    in_i       <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    if (!calm) begin
      while ($urandom_range(99) < 8) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  function automatic in_t make_item(op_e op, logic [7:0] ch, logic ne = 1'b0,
                                    logic [4:0] r = '0, logic [5:0] c = '0);
    in_t it;
    it.op = op; it.char_code = ch; it.no_echo = ne; it.cell_row = r; it.cell_col = c;
    return it;
  endfunction

  // Printable text and control codes, with pushes, pops, reads, clears and undefined ops mixed in
  function automatic in_t random_item();
    in_t it;
    int  pick;
    it = in_t'($bits(in_t)'($urandom));
    pick = $urandom_range(99);
    if (pick < 45) begin
      it.op = OP_WRITE;
      case ($urandom_range(9))
        0: it.char_code = CODE_NL;
        1: it.char_code = CODE_BS;
        2: it.char_code = CODE_TAB;
        3: it.char_code = 8'($urandom_range(255));
        default: it.char_code = 8'($urandom_range(126, 32));
      endcase
    end else if (pick < 60) it.op = OP_PUSH;
    else if (pick < 72) it.op = OP_POP;
    else if (pick < 97) begin
      it.op = OP_READ;
      if ($urandom_range(9) != 0) begin
        it.cell_row = 5'($urandom_range(ROWS_N - 1));
        it.cell_col = 6'($urandom_range(COLS - 1));
      end
    end else if (pick < 98) it.op = OP_CLEAR;
    else it.op = 3'($urandom_range(7, 5));
    return it;
  endfunction

  initial begin
    sb = new();
    rst_ni = 1'b0; in_valid_i = 1'b0; in_i = '0; out_stall_i = 1'b0;
    calm = 1'b0; idle_cycles = 0; n_results = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset glyph, backspace at home, extremes, every op
    send_item(make_item(OP_READ, 8'h00, 1'b0, 5'd0, 6'd0));
    send_item(make_item(OP_WRITE, CODE_BS));
    send_item(make_item(OP_WRITE, 8'hFF));
    send_item(make_item(OP_WRITE, 8'h00));
    send_item(make_item(OP_WRITE, CODE_TAB));
    send_item(make_item(OP_WRITE, CODE_NL));
    send_item(make_item(OP_WRITE, CODE_BS));
    send_item(make_item(OP_READ, 8'hFF, 1'b1, 5'd0, 6'd39));
    send_item(make_item(OP_READ, 8'h00, 1'b0, 5'd31, 6'd63));
    send_item(make_item(OP_READ, 8'h00, 1'b0, 5'd21, 6'd40));
    send_item(make_item(OP_POP, 8'h00));
    for (int i = 0; i < 17; i++) send_item(make_item(OP_PUSH, 8'(i * 15 + 8)));
    for (int i = 0; i < 4; i++) send_item(make_item(OP_POP, 8'h00, i[0]));
    send_item(make_item(op_e'(3'd7), 8'hFF, 1'b1, 5'h1F, 6'h3F));
    send_item(make_item(OP_CLEAR, 8'h00));

    // Pause until the scoreboard drains
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);

    // Fill past the screen with newlines: scrolls, then a stretch without idling
    for (int i = 0; i < ROWS_N + 3; i++) send_item(make_item(OP_WRITE, CODE_NL));
    calm = 1'b1;
    for (int i = 0; i < 90; i++) send_item(random_item());
    calm = 1'b0;
    for (int i = 0; i < N_RANDOM - 90; i++) send_item(random_item());
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d results: text, control codes, scrolls, key FIFO and cell reads",
             n_results);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

`default_nettype wire
